>>> rtl/rcrf_pkg.sv
// Shared types and register codes for the RAMDAC cursor register file.
`default_nettype none
package rcrf_pkg;

  typedef logic [7:0] byte_t;

  // Direct register numbers on reg_select
  typedef enum logic [3:0] {
    REG_WRITE_ADDR   = 4'd0,
    REG_PAL_DATA     = 4'd1,
    REG_PIXEL_MASK   = 4'd2,
    REG_PAL_READ     = 4'd3,
    REG_COLOUR_ADDR  = 4'd4,
    REG_COLOUR_DATA  = 4'd5,
    REG_INDEXED_DATA = 4'd6,
    REG_CURSOR_DATA  = 4'd7,
    REG_X_LOW        = 4'd8,
    REG_X_HIGH       = 4'd9,
    REG_Y_LOW        = 4'd10,
    REG_Y_HIGH       = 4'd11
  } reg_sel_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  localparam logic [3:0] HIGH_MASK = 4'hf;

endpackage
`default_nettype wire

>>> rtl/ramdac_cursor_register_file_top.sv
// Top level of the RAMDAC cursor register file: direct registers, stores and result stage.
`default_nettype none
// One byte-wide bus access per beat. A beat is taken whenever start is high; busy
// never rises, so a new access may be issued in every cycle and the sustained
// rate is one beat per clock. The result of each beat appears on the result ports
// at the edge after the one that takes it, marked by done for exactly
// one cycle, and is taken by the receiver while done is high; the receiver
// cannot stall and must take it then. The latency is set by the
// registered read port of the indirect register and cursor RAM memories, which
// are addressed at the edge that takes the beat; a write by the beat ahead to the
// same entry is forwarded. Indirect registers come up as zero after reset through
// per-entry valid bits, the cursor control register lives in flip-flops of its
// own, and cursor RAM bytes are undefined until written. Accesses to the palette
// data, pixel mask and palette read address go to the external palette DAC and
// are only flagged here with palette_forward, which writes to the write address also raise.
module ramdac_cursor_register_file_top #(
  parameter int unsigned CURSOR_DEPTH        = 1024,
  parameter int unsigned CURSOR_CTRL_INDEX   = 6,
  parameter int unsigned CURSOR_ADDR_BIT     = 2,
  parameter int unsigned PIXEL_STATUS_INDEX  = 47,
  parameter int unsigned MEMORY_STATUS_INDEX = 51,
  parameter int unsigned LOCKED_VALUE        = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation,
  input  wire logic [3:0]          reg_select,
  input  wire rcrf_pkg::byte_t     write_data,
  output logic                     done,
  output rcrf_pkg::byte_t          read_data,
  output logic                     palette_forward,
  output logic                     display_dirty
);
  import rcrf_pkg::*;

  localparam int unsigned CA_W = $clog2(CURSOR_DEPTH);

  localparam byte_t CTRL_IDX   = byte_t'(CURSOR_CTRL_INDEX);
  localparam byte_t PIX_IDX    = byte_t'(PIXEL_STATUS_INDEX);
  localparam byte_t MEM_IDX    = byte_t'(MEMORY_STATUS_INDEX);
  localparam byte_t LOCKED     = byte_t'(LOCKED_VALUE);
  localparam byte_t CTRL_FIELD = byte_t'(8'd3 << CURSOR_ADDR_BIT);

  // Input register: the beat being worked on
  logic       s1_valid;
  logic       s1_op;
  logic [3:0] s1_sel;
  byte_t      s1_data;

  // Architectural state
  byte_t      index_reg;
  byte_t      cursor_ctrl;
  logic [1:0] colour_entry;
  logic [1:0] colour_phase;
  byte_t      colour_store [12];
  byte_t      pos_x_low;
  logic [3:0] pos_x_high;
  byte_t      pos_y_low;
  logic [3:0] pos_y_high;

  // Indirect register memory with valid bits, and cursor RAM
  byte_t      ind_mem [256];
  logic [255:0] ind_vld;
  byte_t      cur_mem [CURSOR_DEPTH];

  // Registered read ports and forwarding
  byte_t      ind_q;
  logic       ind_vld_q;
  logic       ind_byp;
  byte_t      cur_q;
  logic       cur_byp;
  byte_t      byp_data;

  // Next state and stage outputs
  byte_t      index_reg_next;
  byte_t      cursor_ctrl_next;
  logic [1:0] colour_entry_next;
  logic [1:0] colour_phase_next;
  logic       colour_we;
  logic       ind_we;
  logic       cur_we;
  logic       pos_we;
  byte_t      rd;
  logic       fwd;
  logic       dirty;

  logic [3:0]      colour_slot;
  logic [CA_W-1:0] cur_addr;
  logic [CA_W-1:0] cur_addr_inc;
  logic [CA_W-1:0] cur_addr_next;
  logic            idx_status;
  byte_t           ind_value;
  logic [1:0]      phase_inc;

  // No back-pressure towards the host: every beat is taken
  assign busy = 1'b0;

  assign colour_slot  = {1'b0, colour_entry, 1'b0} + {2'b00, colour_entry}
                      + {2'b00, colour_phase};
  assign cur_addr     = CA_W'({cursor_ctrl[CURSOR_ADDR_BIT +: 2], index_reg});
  assign cur_addr_inc = cur_addr + CA_W'(1);
  assign idx_status   = (index_reg == PIX_IDX) || (index_reg == MEM_IDX);
  assign phase_inc    = colour_phase + 2'd1;

  // Indirect read: status registers read locked, control register from its flops,
  // others from memory, forwarded, or zero when never written
  always_comb begin
    if (idx_status) begin
      ind_value = LOCKED;
    end else if (index_reg == CTRL_IDX) begin
      ind_value = cursor_ctrl;
    end else if (ind_byp) begin
      ind_value = byp_data;
    end else if (ind_vld_q) begin
      ind_value = ind_q;
    end else begin
      ind_value = '0;
    end
  end

  always_comb begin
    index_reg_next    = index_reg;
    cursor_ctrl_next  = cursor_ctrl;
    colour_entry_next = colour_entry;
    colour_phase_next = colour_phase;
    colour_we         = 1'b0;
    ind_we            = 1'b0;
    cur_we            = 1'b0;
    pos_we            = 1'b0;
    rd                = '0;
    fwd               = 1'b0;
    dirty             = 1'b0;
    if (s1_valid) begin
      if (s1_op == OP_READ) begin
        case (s1_sel)
          REG_WRITE_ADDR:   rd = index_reg;
          REG_COLOUR_ADDR:  rd = {6'd0, colour_entry};
          REG_COLOUR_DATA:  rd = colour_store[colour_slot];
          REG_INDEXED_DATA: rd = ind_value;
          REG_CURSOR_DATA:  rd = cur_byp ? byp_data : cur_q;
          REG_X_LOW:        rd = pos_x_low;
          REG_X_HIGH:       rd = {4'd0, pos_x_high};
          REG_Y_LOW:        rd = pos_y_low;
          REG_Y_HIGH:       rd = {4'd0, pos_y_high};
          default:          rd = '0;
        endcase
        fwd = s1_sel inside {REG_PAL_DATA, REG_PIXEL_MASK, REG_PAL_READ};
      end else begin
        case (s1_sel)
          REG_WRITE_ADDR: begin
            index_reg_next = s1_data;
          end
          REG_COLOUR_ADDR: begin
            colour_entry_next = s1_data[1:0];
            colour_phase_next = 2'd0;
          end
          REG_COLOUR_DATA: begin
            colour_we = 1'b1;
            dirty     = 1'b1;
          end
          REG_INDEXED_DATA: begin
            if (!idx_status) begin
              dirty = 1'b1;
              if (index_reg == CTRL_IDX) begin
                cursor_ctrl_next = s1_data;
              end else begin
                ind_we = 1'b1;
              end
            end
          end
          REG_CURSOR_DATA: begin
            cur_we = 1'b1;
            dirty  = 1'b1;
          end
          REG_X_LOW, REG_X_HIGH, REG_Y_LOW, REG_Y_HIGH: begin
            pos_we = 1'b1;
          end
          default: begin
          end
        endcase
        fwd = s1_sel inside {[REG_WRITE_ADDR : REG_PAL_READ]};
      end
      // Colour and cursor data accesses advance their pointers either way
      if (s1_sel == REG_COLOUR_DATA) begin
        if (colour_phase >= 2'd2) begin
          colour_phase_next = 2'd0;
          colour_entry_next = colour_entry + 2'd1;
        end else begin
          colour_phase_next = phase_inc;
        end
      end
      if (s1_sel == REG_CURSOR_DATA) begin
        index_reg_next   = cur_addr_inc[7:0];
        cursor_ctrl_next = (cursor_ctrl & ~CTRL_FIELD)
                         | byte_t'({6'd0, cur_addr_inc[CA_W-1:8]} << CURSOR_ADDR_BIT);
      end
    end
  end

  assign cur_addr_next = CA_W'({cursor_ctrl_next[CURSOR_ADDR_BIT +: 2], index_reg_next});

  // Input register and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      done         <= 1'b0;
      index_reg    <= '0;
      cursor_ctrl  <= '0;
      colour_entry <= '0;
      colour_phase <= '0;
      pos_x_low    <= '0;
      pos_x_high   <= '0;
      pos_y_low    <= '0;
      pos_y_high   <= '0;
      ind_vld      <= '0;
      for (int i = 0; i < 12; i++) begin
        colour_store[i] <= '0;
      end
    end else begin
      s1_valid     <= start && !busy;
      done         <= s1_valid;
      index_reg    <= index_reg_next;
      cursor_ctrl  <= cursor_ctrl_next;
      colour_entry <= colour_entry_next;
      colour_phase <= colour_phase_next;
      if (colour_we) begin
        colour_store[colour_slot] <= s1_data;
      end
      if (ind_we) begin
        ind_vld[index_reg] <= 1'b1;
      end
      if (pos_we) begin
        case (s1_sel)
          REG_X_LOW:  pos_x_low  <= s1_data;
          REG_X_HIGH: pos_x_high <= s1_data[3:0] & HIGH_MASK;
          REG_Y_LOW:  pos_y_low  <= s1_data;
          REG_Y_HIGH: pos_y_high <= s1_data[3:0] & HIGH_MASK;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload of the beat and the result stage
  always_ff @(posedge clk) begin
    s1_op           <= operation;
    s1_sel          <= reg_select;
    s1_data         <= write_data;
    read_data       <= rd;
    palette_forward <= fwd;
    display_dirty   <= dirty;
  end

  // Indirect memory: write the beat in hand, read for the next one
  always_ff @(posedge clk) begin
    if (ind_we) begin
      ind_mem[index_reg] <= s1_data;
    end
    ind_q     <= ind_mem[index_reg_next];
    ind_vld_q <= ind_vld[index_reg_next];
    ind_byp   <= ind_we && (index_reg == index_reg_next);
    byp_data  <= s1_data;
  end

  // Cursor RAM: same scheme
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_addr] <= s1_data;
    end
    cur_q   <= cur_mem[cur_addr_next];
    cur_byp <= cur_we && (cur_addr == cur_addr_next);
  end

endmodule
`default_nettype wire

>>> rtl/rcrf_checker.sv
// Port-level checks for the RAMDAC cursor register file, bound to the top level.
`default_nettype none
module rcrf_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            operation,
  input wire logic [3:0]      reg_select,
  input wire logic            done,
  input wire rcrf_pkg::byte_t read_data,
  input wire logic            palette_forward,
  input wire logic            display_dirty
);
  import rcrf_pkg::*;

  // Every beat taken yields its result, through the input register and the result register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("beat taken without a result");

  // No result without a matching beat taken earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a beat");

  // Forwarded and dirty accesses never return data
  a_quiet_data: assert property (@(posedge clk) disable iff (rst)
    done && (palette_forward || display_dirty) |-> read_data == '0)
    else $error("data returned on forwarded or dirty access");

  // A read of cursor X high shows four bits only
  a_high_nibble: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_READ && reg_select == REG_X_HIGH
    |-> ##2 read_data[7:4] == 4'd0)
    else $error("cursor high byte wider than four bits");

endmodule

bind ramdac_cursor_register_file_top rcrf_checker u_rcrf_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .operation       (operation),
  .reg_select      (reg_select),
  .done            (done),
  .read_data       (read_data),
  .palette_forward (palette_forward),
  .display_dirty   (display_dirty)
);
`default_nettype wire

>>> bench/rcrf_access_checker.sv
// Checker for the RAMDAC cursor register file: watches the beats, predicts each result and compares.
module rcrf_access_checker #(
  parameter int unsigned CURSOR_CTRL_INDEX   = 6,
  parameter int unsigned CURSOR_ADDR_BIT     = 2,
  parameter int unsigned PIXEL_STATUS_INDEX  = 47,
  parameter int unsigned MEMORY_STATUS_INDEX = 51,
  parameter int unsigned LOCKED_VALUE        = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             operation,
  input  logic [3:0]       reg_select,
  input  rcrf_pkg::byte_t  write_data,
  input  logic             done,
  input  rcrf_pkg::byte_t  read_data,
  input  logic             palette_forward,
  input  logic             display_dirty,
  output int               mismatches,
  output int               results_checked,
  output int               pending,
  output logic             cursor_byte_known
);
  import rcrf_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  forward;
    logic  dirty;
  } access_result_t;

  access_result_t due_register_results [$];
  access_result_t predicted;
  access_result_t oldest;

  byte_t      addr_index;
  logic [1:0] col_entry;
  logic [1:0] col_phase;
  byte_t      col_ram [12];
  byte_t      sprite_ram [1024];
  logic       sprite_seen [1024];
  byte_t      ind_regs [256];
  byte_t      xpos_lo;
  logic [3:0] xpos_hi;
  byte_t      ypos_lo;
  logic [3:0] ypos_hi;

  task automatic clear_model();
    addr_index = '0;
    col_entry = '0;
    col_phase = '0;
    xpos_lo = '0;
    xpos_hi = '0;
    ypos_lo = '0;
    ypos_hi = '0;
    for (int i = 0; i < 12; i++) col_ram[i] = '0;
    for (int i = 0; i < 256; i++) ind_regs[i] = '0;
    for (int i = 0; i < 1024; i++) begin
      sprite_ram[i] = '0;
      sprite_seen[i] = 1'b0;
    end
  endtask

  function automatic int col_slot();
    return int'(col_entry) * 3 + int'(col_phase);
  endfunction

  // Advance the byte within the colour entry, then the entry modulo four.
  task automatic step_colour();
    if (col_phase == 2'd2) begin
      col_phase = '0;
      col_entry = col_entry + 2'd1;
    end else begin
      col_phase = col_phase + 2'd1;
    end
  endtask

  // Two address bits from the cursor control register above the write index.
  function automatic logic [9:0] sprite_addr();
    return {ind_regs[CURSOR_CTRL_INDEX][CURSOR_ADDR_BIT +: 2], addr_index};
  endfunction

  task automatic step_sprite(input logic [9:0] addr);
    logic [9:0] next;
    next = addr + 10'd1;
    addr_index = next[7:0];
    ind_regs[CURSOR_CTRL_INDEX][CURSOR_ADDR_BIT +: 2] = next[9:8];
  endtask

  function automatic logic is_clock_status(input byte_t idx);
    return idx == PIXEL_STATUS_INDEX || idx == MEMORY_STATUS_INDEX;
  endfunction

  task automatic compute_register_access(input op_t op, input logic [3:0] sel,
                                         input byte_t data, output access_result_t res);
    logic [9:0] addr;
    res = '0;
    addr = sprite_addr();
    if (op == OP_READ) begin
      case (sel)
        REG_WRITE_ADDR: res.data = addr_index;
        REG_PAL_DATA, REG_PIXEL_MASK, REG_PAL_READ: res.forward = 1'b1;
        REG_COLOUR_ADDR: res.data = {6'd0, col_entry};
        REG_COLOUR_DATA: begin
          res.data = col_ram[col_slot()];
          step_colour();
        end
        REG_INDEXED_DATA: begin
          res.data = is_clock_status(addr_index) ? byte_t'(LOCKED_VALUE)
                                                 : ind_regs[addr_index];
        end
        REG_CURSOR_DATA: begin
          res.data = sprite_ram[addr];
          step_sprite(addr);
        end
        REG_X_LOW: res.data = xpos_lo;
        REG_X_HIGH: res.data = {4'd0, xpos_hi};
        REG_Y_LOW: res.data = ypos_lo;
        REG_Y_HIGH: res.data = {4'd0, ypos_hi};
        default: ;
      endcase
    end else begin
      case (sel)
        REG_WRITE_ADDR: begin
          addr_index = data;
          res.forward = 1'b1;
        end
        REG_PAL_DATA, REG_PIXEL_MASK, REG_PAL_READ: res.forward = 1'b1;
        REG_COLOUR_ADDR: begin
          col_entry = data[1:0];
          col_phase = '0;
        end
        REG_COLOUR_DATA: begin
          col_ram[col_slot()] = data;
          step_colour();
          res.dirty = 1'b1;
        end
        REG_INDEXED_DATA: begin
          if (!is_clock_status(addr_index)) begin
            ind_regs[addr_index] = data;
            res.dirty = 1'b1;
          end
        end
        REG_CURSOR_DATA: begin
          sprite_ram[addr] = data;
          sprite_seen[addr] = 1'b1;
          step_sprite(addr);
          res.dirty = 1'b1;
        end
        REG_X_LOW: xpos_lo = data;
        REG_X_HIGH: xpos_hi = data[3:0] & HIGH_MASK;
        REG_Y_LOW: ypos_lo = data;
        REG_Y_HIGH: ypos_hi = data[3:0] & HIGH_MASK;
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      due_register_results.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (start && !busy) begin
        compute_register_access(op_t'(operation), reg_select, write_data, predicted);
        due_register_results.push_back(predicted);
      end
      if (done === 1'b1) begin
        if (due_register_results.size() == 0) begin
          $error("result with no beat outstanding: read_data %02h", read_data);
          mismatches++;
        end else begin
          oldest = due_register_results.pop_front();
          results_checked++;
          if (read_data !== oldest.data) begin
            $error("read_data: expected %02h, got %02h", oldest.data, read_data);
            mismatches++;
          end
          if (palette_forward !== oldest.forward) begin
            $error("palette_forward: expected %b, got %b", oldest.forward, palette_forward);
            mismatches++;
          end
          if (display_dirty !== oldest.dirty) begin
            $error("display_dirty: expected %b, got %b", oldest.dirty, display_dirty);
            mismatches++;
          end
        end
      end
    end
    pending <= due_register_results.size();
    cursor_byte_known <= sprite_seen[sprite_addr()];
  end

endmodule

>>> bench/testbench.sv
// Top of the RAMDAC cursor register file testbench: clock, reset, beat stimulus and verdict.
module testbench;
  import rcrf_pkg::*;

  localparam int unsigned CTRL_IDX       = 6;
  localparam int unsigned ADDR_BIT       = 2;
  localparam int unsigned PIXEL_STAT_IDX = 47;
  localparam int unsigned MEM_STAT_IDX   = 51;
  localparam int unsigned LOCKED_BYTE    = 16;

  // Random beats per idle setting; four settings give at least 760 beats.
  localparam int BEATS_PER_PHASE = 190;
  // Longest run of idle cycles before one beat.
  localparam int MAX_GAP         = 64;
  // Idle cycles allowed after the last result has come back, before the verdict.
  localparam int SETTLE_CYCLES   = 8;
  // Slowest run: ~800 beats each behind the longest gap, taken several times over.
  localparam int CYCLE_LIMIT     = 200000;
  localparam logic [3:0] SEL_SPARE_FIRST = 4'd12;
  localparam logic [3:0] SEL_SPARE_LAST  = 4'd15;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       operation = 1'b0;
  logic [3:0] reg_select = '0;
  byte_t      write_data = '0;
  logic       busy;
  logic       done;
  byte_t      read_data;
  logic       palette_forward;
  logic       display_dirty;

  int   mismatches;
  int   results_checked;
  int   pending;
  logic cursor_byte_known;

  int idle_pct = 0;
  int beats_sent = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ramdac_cursor_register_file_top #(
    .CURSOR_DEPTH        (1024),
    .CURSOR_CTRL_INDEX   (CTRL_IDX),
    .CURSOR_ADDR_BIT     (ADDR_BIT),
    .PIXEL_STATUS_INDEX  (PIXEL_STAT_IDX),
    .MEMORY_STATUS_INDEX (MEM_STAT_IDX),
    .LOCKED_VALUE        (LOCKED_BYTE)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .reg_select      (reg_select),
    .write_data      (write_data),
    .done            (done),
    .read_data       (read_data),
    .palette_forward (palette_forward),
    .display_dirty   (display_dirty)
  );

  rcrf_access_checker #(
    .CURSOR_CTRL_INDEX   (CTRL_IDX),
    .CURSOR_ADDR_BIT     (ADDR_BIT),
    .PIXEL_STATUS_INDEX  (PIXEL_STAT_IDX),
    .MEMORY_STATUS_INDEX (MEM_STAT_IDX),
    .LOCKED_VALUE        (LOCKED_BYTE)
  ) u_chk (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .operation         (operation),
    .reg_select        (reg_select),
    .write_data        (write_data),
    .done              (done),
    .read_data         (read_data),
    .palette_forward   (palette_forward),
    .display_dirty     (display_dirty),
    .mismatches        (mismatches),
    .results_checked   (results_checked),
    .pending           (pending),
    .cursor_byte_known (cursor_byte_known)
  );

  // Abandon the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Favour the extremes of a byte, otherwise any value.
  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // Issue one beat. Called and returns at a falling edge. An idle gap drawn from
  // idle_pct comes first, with junk on the fields while start is low.
  task automatic send_beat(input op_t op, input logic [3:0] sel, input byte_t data);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      operation <= 1'($urandom_range(1));
      reg_select <= 4'($urandom_range(15));
      write_data <= byte_t'($urandom_range(255));
      repeat (gap) @(negedge clk);
    end
    // A cursor RAM byte never written holds no defined value: write it instead.
    if (op == OP_READ && sel == REG_CURSOR_DATA && !cursor_byte_known) op = OP_WRITE;
    start <= 1'b1;
    operation <= op;
    reg_select <= sel;
    write_data <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    byte_t idx;
    byte_t ctrl_val;
    byte_t base;
    int    n;
    int    phase_end;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats, back to back.
    // Write index at its extremes.
    send_beat(OP_READ,  REG_WRITE_ADDR, 8'h00);
    send_beat(OP_WRITE, REG_WRITE_ADDR, 8'hff);
    send_beat(OP_READ,  REG_WRITE_ADDR, 8'h00);
    // Clock status registers: locked value, writes dropped and not dirty.
    send_beat(OP_WRITE, REG_WRITE_ADDR, byte_t'(PIXEL_STAT_IDX));
    send_beat(OP_WRITE, REG_INDEXED_DATA, 8'haa);
    send_beat(OP_READ,  REG_INDEXED_DATA, 8'h00);
    send_beat(OP_WRITE, REG_WRITE_ADDR, byte_t'(MEM_STAT_IDX));
    send_beat(OP_READ,  REG_INDEXED_DATA, 8'h00);
    // Colour store: last entry, then wrap of the entry back to zero.
    send_beat(OP_WRITE, REG_COLOUR_ADDR, 8'hff);
    send_beat(OP_WRITE, REG_COLOUR_DATA, 8'h00);
    send_beat(OP_WRITE, REG_COLOUR_DATA, 8'hff);
    send_beat(OP_WRITE, REG_COLOUR_DATA, 8'h5a);
    send_beat(OP_READ,  REG_COLOUR_ADDR, 8'h00);
    // Cursor RAM across the top of its address range, then read back.
    send_beat(OP_WRITE, REG_WRITE_ADDR, byte_t'(CTRL_IDX));
    send_beat(OP_WRITE, REG_INDEXED_DATA, 8'h0c);
    send_beat(OP_WRITE, REG_WRITE_ADDR, 8'hff);
    send_beat(OP_WRITE, REG_CURSOR_DATA, 8'ha5);
    send_beat(OP_WRITE, REG_CURSOR_DATA, 8'h3c);
    send_beat(OP_WRITE, REG_WRITE_ADDR, byte_t'(CTRL_IDX));
    send_beat(OP_WRITE, REG_INDEXED_DATA, 8'h0c);
    send_beat(OP_WRITE, REG_WRITE_ADDR, 8'hff);
    send_beat(OP_READ,  REG_CURSOR_DATA, 8'h00);
    send_beat(OP_READ,  REG_CURSOR_DATA, 8'h00);
    // Cursor high byte keeps four bits only.
    send_beat(OP_WRITE, REG_X_HIGH, 8'hff);
    send_beat(OP_READ,  REG_X_HIGH, 8'h00);
    // Palette accesses are flagged; spare numbers are inert.
    send_beat(OP_READ,  REG_PAL_DATA, 8'h00);
    send_beat(OP_WRITE, REG_PIXEL_MASK, 8'hff);
    send_beat(OP_WRITE, SEL_SPARE_LAST, 8'hff);
    send_beat(OP_READ,  SEL_SPARE_FIRST, 8'h00);

    // Random sequences under four idle settings: none, heavy, none, light.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 86 : (phase == 3) ? 6 : 0;
      // Drain between settings so every phase starts from an idle block.
      wait_for_results();
      phase_end = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < phase_end) begin
        case ($urandom_range(9))
          0, 1: begin
            // Point the index at an indirect register, then access it a few times.
            case ($urandom_range(4))
              0: idx = byte_t'(PIXEL_STAT_IDX);
              1: idx = byte_t'(MEM_STAT_IDX);
              2: idx = byte_t'(CTRL_IDX);
              default: idx = pick_byte();
            endcase
            send_beat(OP_WRITE, REG_WRITE_ADDR, idx);
            n = $urandom_range(4, 1);
            repeat (n) send_beat(op_t'($urandom_range(1)), REG_INDEXED_DATA, pick_byte());
          end
          2, 3: begin
            // Colour store walk, sometimes from a fresh entry.
            if ($urandom_range(1)) send_beat(OP_WRITE, REG_COLOUR_ADDR, pick_byte());
            n = $urandom_range(7, 1);
            repeat (n) send_beat(op_t'($urandom_range(1)), REG_COLOUR_DATA, pick_byte());
            if ($urandom_range(3) == 0) send_beat(OP_READ, REG_COLOUR_ADDR, 8'h00);
          end
          4, 5: begin
            // Cursor RAM burst, usually read back from the same start address.
            ctrl_val = pick_byte();
            base = pick_byte();
            n = $urandom_range(8, 1);
            send_beat(OP_WRITE, REG_WRITE_ADDR, byte_t'(CTRL_IDX));
            send_beat(OP_WRITE, REG_INDEXED_DATA, ctrl_val);
            send_beat(OP_WRITE, REG_WRITE_ADDR, base);
            repeat (n) send_beat(OP_WRITE, REG_CURSOR_DATA, pick_byte());
            if ($urandom_range(3) != 0) begin
              send_beat(OP_WRITE, REG_WRITE_ADDR, byte_t'(CTRL_IDX));
              send_beat(OP_WRITE, REG_INDEXED_DATA, ctrl_val);
              send_beat(OP_WRITE, REG_WRITE_ADDR, base);
              repeat (n) send_beat(OP_READ, REG_CURSOR_DATA, pick_byte());
            end
          end
          6: begin
            send_beat(op_t'($urandom_range(1)), 4'(REG_X_LOW + $urandom_range(3)),
                      pick_byte());
          end
          7: begin
            send_beat(op_t'($urandom_range(1)),
                      4'($urandom_range(REG_PAL_READ, REG_WRITE_ADDR)), pick_byte());
          end
          default: begin
            // Noise over every register number, spare ones included.
            send_beat(op_t'($urandom_range(1)), 4'($urandom_range(15)), pick_byte());
          end
        endcase
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d register beats under four idle settings, %0d results compared",
             beats_sent, results_checked);
    $display("sequences: indirect and clock status, colour walks, cursor RAM bursts, noise");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> ramdac_cursor_register_file_top.f
rtl/rcrf_pkg.sv
rtl/ramdac_cursor_register_file_top.sv
rtl/rcrf_checker.sv
bench/rcrf_access_checker.sv
bench/testbench.sv
